// ===== rtl/ekc_pkg.sv =====
// shared types and constants for the expiring key cache
// no dependencies; imported by every module of the block
`default_nettype none

package ekc_pkg;

  localparam int ENTRIES     = 128;
  localparam int POLICY_BITS = 16;
  localparam int TIME_BITS   = 48;
  localparam int KEY_W       = 32;
  localparam int GEN_W       = 32;
  localparam int LIFE_W      = 32;
  localparam int IDX_W       = $clog2(ENTRIES);
  localparam int CNT_W       = $clog2(ENTRIES + 1);
  localparam int AGE_W       = (TIME_BITS > LIFE_W) ? TIME_BITS : LIFE_W;

  localparam logic [LIFE_W-1:0] LIFETIME_RESET = LIFE_W'(30000);

  // request actions
  localparam logic [1:0] ACT_LOOKUP     = 2'd0;
  localparam logic [1:0] ACT_PUBLISH    = 2'd1;
  localparam logic [1:0] ACT_INVALIDATE = 2'd2;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_GENERATION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIFETIME   = 2'd1;

  typedef struct packed {
    logic [1:0]             action;
    logic [KEY_W-1:0]       process_key;
    logic [TIME_BITS-1:0]   now_ms;
    logic [POLICY_BITS-1:0] policy_in;
  } req_t;

  typedef struct packed {
    logic                   hit;
    logic [POLICY_BITS-1:0] policy_out;
    logic [TIME_BITS-1:0]   stamp_out;
    logic                   evicted;
  } rsp_t;

  typedef struct packed {
    logic [KEY_W-1:0]       key;
    logic [TIME_BITS-1:0]   stamp;
    logic [GEN_W-1:0]       gen;
    logic [POLICY_BITS-1:0] policy;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic issue;
    logic finish;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic req_scan;
    logic issue_done;
    logic scan_done;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

// ===== rtl/ekc_ctrl.sv =====
// controller state machine for the expiring key cache
// depends on ekc_pkg; drives commands to ekc_dpath
`default_nettype none

module ekc_ctrl import ekc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    req_valid,
  output logic    req_stall,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_FINISH = 3'b100
  } state_t;

  state_t state, state_next;

  assign req_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = status.req_scan ? S_SCAN : S_FINISH;
        end
      end
      S_SCAN: begin
        cmd.issue = !status.issue_done;
        if (status.scan_done) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ekc_dpath.sv =====
// datapath: record memory, valid bits, scan trackers, config and result registers
// depends on ekc_pkg; commanded by ekc_ctrl
`default_nettype none

module ekc_dpath import ekc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  req_t                 req,
  input  cmd_t                 cmd,
  output status_t              status,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output rsp_t                 rsp
);

  logic [GEN_W-1:0]  cfg_gen;
  logic [LIFE_W-1:0] cfg_life;
  req_t              cur_req;

  entry_t             mem [ENTRIES];
  entry_t             rd_entry;
  logic [ENTRIES-1:0] valid;
  logic               rd_valid;

  logic [CNT_W-1:0] issue_cnt;
  logic             chk;
  logic [IDX_W-1:0] chk_idx;

  logic                   match_found;
  logic [IDX_W-1:0]       match_idx;
  logic [TIME_BITS-1:0]   match_stamp;
  logic [GEN_W-1:0]       match_gen;
  logic [POLICY_BITS-1:0] match_policy;
  logic                   free_found;
  logic [IDX_W-1:0]       free_idx;
  logic [TIME_BITS-1:0]   oldest_stamp;
  logic [IDX_W-1:0]       oldest_idx;

  logic                 issue_done;
  logic                 is_lookup;
  logic                 is_publish;
  logic                 lookup_hit;
  logic [TIME_BITS-1:0] age;
  logic [IDX_W-1:0]     tgt_idx;
  logic                 do_evict;
  entry_t               wr_entry;
  rsp_t                 rsp_next;

  assign issue_done = (issue_cnt == CNT_W'(ENTRIES));
  assign is_lookup  = (cur_req.action == ACT_LOOKUP);
  assign is_publish = (cur_req.action == ACT_PUBLISH);

  assign status.req_scan   = (req.action == ACT_LOOKUP) || (req.action == ACT_PUBLISH);
  assign status.issue_done = issue_done;
  assign status.scan_done  = issue_done && !chk;
  assign status.out_free   = !rsp_valid || !rsp_stall;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_gen  <= '0;
      cfg_life <= LIFETIME_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_GENERATION: cfg_gen  <= cfg_data[GEN_W-1:0];
        CFG_LIFETIME:   cfg_life <= cfg_data[LIFE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_req <= req;
    end
  end

  // finish-time decisions
  assign age = cur_req.now_ms - match_stamp;
  assign lookup_hit = match_found && (match_gen == cfg_gen) &&
                      (cur_req.now_ms >= match_stamp) &&
                      (AGE_W'(age) <= AGE_W'(cfg_life));
  assign do_evict = !match_found && !free_found;
  assign tgt_idx  = match_found ? match_idx : (free_found ? free_idx : oldest_idx);

  always_comb begin
    wr_entry.key    = cur_req.process_key;
    wr_entry.stamp  = cur_req.now_ms;
    wr_entry.gen    = cfg_gen;
    wr_entry.policy = cur_req.policy_in;
  end

  always_comb begin
    rsp_next = '0;
    if (is_lookup && lookup_hit) begin
      rsp_next.hit        = 1'b1;
      rsp_next.policy_out = match_policy;
      rsp_next.stamp_out  = match_stamp;
    end
    if (is_publish) begin
      rsp_next.evicted = do_evict;
    end
  end

  // record memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (cmd.finish && is_publish) begin
      mem[tgt_idx] <= wr_entry;
    end
    rd_entry <= mem[issue_cnt[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (cmd.finish && is_publish) begin
      valid[tgt_idx] <= 1'b1;
    end else if (cmd.finish && (cur_req.action == ACT_INVALIDATE)) begin
      valid <= '0;
    end
  end

  // scan counter and compare pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      issue_cnt <= '0;
      chk       <= 1'b0;
    end else begin
      if (cmd.load) begin
        issue_cnt <= '0;
      end else if (cmd.issue) begin
        issue_cnt <= issue_cnt + CNT_W'(1);
      end
      chk <= cmd.issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      chk_idx  <= issue_cnt[IDX_W-1:0];
      rd_valid <= valid[issue_cnt[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      match_found <= 1'b0;
      free_found  <= 1'b0;
    end else if (chk) begin
      if (rd_valid && (rd_entry.key == cur_req.process_key) && !match_found) begin
        match_found  <= 1'b1;
        match_idx    <= chk_idx;
        match_stamp  <= rd_entry.stamp;
        match_gen    <= rd_entry.gen;
        match_policy <= rd_entry.policy;
      end
      if (!rd_valid && !free_found) begin
        free_found <= 1'b1;
        free_idx   <= chk_idx;
      end
      // strict compare keeps the lowest slot on ties
      if ((chk_idx == '0) || (rd_entry.stamp < oldest_stamp)) begin
        oldest_stamp <= rd_entry.stamp;
        oldest_idx   <= chk_idx;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.finish) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      rsp <= rsp_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/expiring_key_cache_oldest_evict.sv =====
// top level of the expiring key cache with oldest-record eviction
// depends on ekc_pkg, ekc_ctrl and ekc_dpath
//
// a keyed store of ENTRIES records (key, stamp, generation, policy word).
// lookup and publish requests walk the whole record memory one slot a cycle
// through its single registered read port before their result is loaded
// into the output register; invalidate and the unused action code skip the
// scan. the next request can be accepted the cycle after the result is
// loaded into the output register, even while that result still waits on
// rsp_stall; a request that completes while the output register is still
// held keeps req_stall high until it drains.
// valid bits live in flip-flops and clear at reset, so there is no clearing
// pass. configuration writes are taken at any time (cfg_ready is always
// high) but must only be issued while the block is idle.
`default_nettype none

module expiring_key_cache_oldest_evict import ekc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  // request channel
  input  logic                 req_valid,
  output logic                 req_stall,
  input  req_t                 req,
  // result channel
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output rsp_t                 rsp,
  // configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  cmd_t    cmd;
  status_t status;

  // config registers are plain flops, always writable
  assign cfg_ready = 1'b1;

  // sequencing: idle, scan all slots for lookup and publish, then write back and load the result
  ekc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // record memory, scan trackers and output register
  ekc_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .status    (status),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire
